// ===== hdl/cscm_pkg.sv =====
// ----------------------------------------------------------------------------
// cscm_pkg
// Shared widths, mode codes and the channel types for the colour space
// matrix converter.
// ----------------------------------------------------------------------------
package cscm_pkg;

	// channel widths
	localparam int CH_W = 8;
	localparam int X_W  = CH_W + 1;
	localparam int MODE_W = 2;

	// conversion modes
	localparam logic [MODE_W-1:0] MODE_PASS   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_YCBCR  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RGB    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_YPBPR  = 2'd3;

	// channel after its input offset
	typedef logic signed [X_W-1:0] chan_x_t;

	// unsigned 8-bit channel
	typedef logic [CH_W-1:0] chan_t;

endpackage

// ===== hdl/cscm_row.sv =====
// ----------------------------------------------------------------------------
// cscm_row
// One output row of the matrix: three products, sum with offset and
// rounding half, then saturation to 0..255 with a clip flag.
// ----------------------------------------------------------------------------
module cscm_row #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                              clk,
	input  logic signed [COEF_FRAC_BITS+2:0]  coef_0,
	input  logic signed [COEF_FRAC_BITS+2:0]  coef_1,
	input  logic signed [COEF_FRAC_BITS+2:0]  coef_2,
	input  cscm_pkg::chan_x_t                 x_0,
	input  cscm_pkg::chan_x_t                 x_1,
	input  cscm_pkg::chan_x_t                 x_2,
	input  cscm_pkg::chan_t                   post_off,
	output cscm_pkg::chan_t                   res,
	output logic                              clip
);
	import cscm_pkg::*;

	localparam int CW = COEF_FRAC_BITS + 3;
	localparam int PW = CW + X_W;
	localparam int AW = COEF_FRAC_BITS + 14;
	localparam int VW = AW - COEF_FRAC_BITS;

	logic signed [PW-1:0] prod0_s2, prod1_s2, prod2_s2;
	chan_t                post_s2;
	logic signed [AW-1:0] acc_s3;
	logic signed [AW-1:0] acc_d;
	logic signed [VW-1:0] val;
	chan_t                res_s4;
	logic                 clip_s4;

	// products
	always_ff @(posedge clk) begin
		prod0_s2 <= PW'(coef_0 * x_0);
		prod1_s2 <= PW'(coef_1 * x_1);
		prod2_s2 <= PW'(coef_2 * x_2);
		post_s2  <= post_off;
	end

	// sum with output offset and rounding half
	always_comb begin
		acc_d = AW'(prod0_s2) + AW'(prod1_s2) + AW'(prod2_s2)
			+ (AW'($signed({1'b0, post_s2})) <<< COEF_FRAC_BITS)
			+ (AW'(1) <<< (COEF_FRAC_BITS - 1));
	end

	always_ff @(posedge clk) begin
		acc_s3 <= acc_d;
	end

	// floor shift and saturation
	assign val = VW'(acc_s3 >>> COEF_FRAC_BITS);

	always_ff @(posedge clk) begin
		if (acc_s3 < 0) begin
			res_s4  <= '0;
			clip_s4 <= 1'b1;
		end else if (val > VW'(255)) begin
			res_s4  <= '1;
			clip_s4 <= 1'b1;
		end else begin
			res_s4  <= val[CH_W-1:0];
			clip_s4 <= 1'b0;
		end
	end

	assign res  = res_s4;
	assign clip = clip_s4;

endmodule

// ===== hdl/color_space_matrix_converter.sv =====
// ----------------------------------------------------------------------------
// color_space_matrix_converter
// Pixel colour space conversion by a fixed-point 3x3 matrix, four modes.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel request is taken on chan_a/b/c at a rising edge with start high
//   and busy low. busy is always low: a new pixel may enter every cycle.
//   Each result appears on res_a/b/c and clipped for exactly one cycle,
//   marked by done; throughput is one pixel per clock. The receiver cannot
//   stall the block.
//   Stages: coefficient and input offset select, products, sum with
//   rounding, saturation into the output register. The multiply stage
//   (one 9-bit by COEF_FRAC_BITS+3 product per term) sets the stage depth.
//   Write the mode register through mode_we/mode_wdata only while no pixel
//   is in flight; the block does not enforce it. Each pixel carries its mode
//   down the pipeline. Reset clears the mode to pass-through and empties
//   the pipeline; pixels in flight are lost, no results are repeated.
// ----------------------------------------------------------------------------
module color_space_matrix_converter #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          mode_we,
	input  logic [cscm_pkg::MODE_W-1:0]   mode_wdata,
	input  logic                          start,
	output logic                          busy,
	input  cscm_pkg::chan_t               chan_a,
	input  cscm_pkg::chan_t               chan_b,
	input  cscm_pkg::chan_t               chan_c,
	output logic                          done,
	output cscm_pkg::chan_t               res_a,
	output cscm_pkg::chan_t               res_b,
	output cscm_pkg::chan_t               res_c,
	output logic                          clipped
);
	import cscm_pkg::*;

	localparam int F  = COEF_FRAC_BITS;
	localparam int CW = COEF_FRAC_BITS + 3;

	// coefficient magnitudes, rounded half away from zero
	localparam longint K_ONE = longint'(1) << F;
	localparam longint K1_00 = ((longint'(65481)  << F) + 127500) / 255000;
	localparam longint K1_01 = ((longint'(128553) << F) + 127500) / 255000;
	localparam longint K1_02 = ((longint'(24966)  << F) + 127500) / 255000;
	localparam longint K1_10 = ((longint'(37797)  << F) + 127500) / 255000;
	localparam longint K1_11 = ((longint'(74203)  << F) + 127500) / 255000;
	localparam longint K1_12 = ((longint'(112000) << F) + 127500) / 255000;
	localparam longint K1_21 = ((longint'(93786)  << F) + 127500) / 255000;
	localparam longint K1_22 = ((longint'(18214)  << F) + 127500) / 255000;
	localparam longint K2_Y  = ((longint'(255)    << F) + 109) / 219;
	localparam longint K2_02 = ((longint'(178755) << F) + 56000) / 112000;
	localparam longint K2_11 = ((longint'(25756020) << F) + 32872000) / 65744000;
	localparam longint K2_12 = ((longint'(53447745) << F) + 32872000) / 65744000;
	localparam longint K2_21 = ((longint'(225930) << F) + 56000) / 112000;
	localparam longint K3_00 = ((longint'(299000) << F) + 500000) / 1000000;
	localparam longint K3_01 = ((longint'(587000) << F) + 500000) / 1000000;
	localparam longint K3_02 = ((longint'(114000) << F) + 500000) / 1000000;
	localparam longint K3_10 = ((longint'(168736) << F) + 500000) / 1000000;
	localparam longint K3_11 = ((longint'(331264) << F) + 500000) / 1000000;
	localparam longint K3_12 = ((longint'(500000) << F) + 500000) / 1000000;
	localparam longint K3_21 = ((longint'(418688) << F) + 500000) / 1000000;
	localparam longint K3_22 = ((longint'(81312)  << F) + 500000) / 1000000;

	typedef logic signed [CW-1:0] coef_t;

	logic [MODE_W-1:0] mode_q;
	coef_t             coef_d [3][3];
	coef_t             coef_s1 [3][3];
	chan_t             post_d [3];
	chan_t             post_s1 [3];
	chan_x_t           x_d [3];
	chan_x_t           x_s1 [3];
	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	logic              clip_a, clip_b, clip_c;
	logic              take;

	assign busy = 1'b0;
	assign take = start && !busy;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PASS;
		end else if (mode_we) begin
			mode_q <= mode_wdata;
		end
	end

	// coefficient, input and output offset select
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				coef_d[r][c] = '0;
			end
			post_d[r] = '0;
		end
		x_d[0] = chan_x_t'({1'b0, chan_a});
		x_d[1] = chan_x_t'({1'b0, chan_b});
		x_d[2] = chan_x_t'({1'b0, chan_c});
		case (mode_q)
			MODE_PASS: begin
				coef_d[0][0] = CW'(K_ONE);
				coef_d[1][1] = CW'(K_ONE);
				coef_d[2][2] = CW'(K_ONE);
			end
			MODE_YCBCR: begin
				coef_d[0][0] = CW'(K1_00);
				coef_d[0][1] = CW'(K1_01);
				coef_d[0][2] = CW'(K1_02);
				coef_d[1][0] = CW'(-K1_10);
				coef_d[1][1] = CW'(-K1_11);
				coef_d[1][2] = CW'(K1_12);
				coef_d[2][0] = CW'(K1_12);
				coef_d[2][1] = CW'(-K1_21);
				coef_d[2][2] = CW'(-K1_22);
				post_d[0] = 8'd16;
				post_d[1] = 8'd128;
				post_d[2] = 8'd128;
			end
			MODE_RGB: begin
				coef_d[0][0] = CW'(K2_Y);
				coef_d[0][2] = CW'(K2_02);
				coef_d[1][0] = CW'(K2_Y);
				coef_d[1][1] = CW'(-K2_11);
				coef_d[1][2] = CW'(-K2_12);
				coef_d[2][0] = CW'(K2_Y);
				coef_d[2][1] = CW'(K2_21);
				x_d[0] = chan_x_t'({1'b0, chan_a}) - chan_x_t'(16);
				x_d[1] = chan_x_t'({1'b0, chan_b}) - chan_x_t'(128);
				x_d[2] = chan_x_t'({1'b0, chan_c}) - chan_x_t'(128);
			end
			MODE_YPBPR: begin
				coef_d[0][0] = CW'(K3_00);
				coef_d[0][1] = CW'(K3_01);
				coef_d[0][2] = CW'(K3_02);
				coef_d[1][0] = CW'(-K3_10);
				coef_d[1][1] = CW'(-K3_11);
				coef_d[1][2] = CW'(K3_12);
				coef_d[2][0] = CW'(K3_12);
				coef_d[2][1] = CW'(-K3_21);
				coef_d[2][2] = CW'(-K3_22);
				post_d[1] = 8'd128;
				post_d[2] = 8'd128;
			end
			default: begin
				coef_d[0][0] = '0;
			end
		endcase
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		coef_s1 <= coef_d;
		post_s1 <= post_d;
		x_s1    <= x_d;
	end

	// valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// one row per output channel
	cscm_row #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_row_a (
		.clk      (clk),
		.coef_0   (coef_s1[0][0]),
		.coef_1   (coef_s1[0][1]),
		.coef_2   (coef_s1[0][2]),
		.x_0      (x_s1[0]),
		.x_1      (x_s1[1]),
		.x_2      (x_s1[2]),
		.post_off (post_s1[0]),
		.res      (res_a),
		.clip     (clip_a)
	);

	cscm_row #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_row_b (
		.clk      (clk),
		.coef_0   (coef_s1[1][0]),
		.coef_1   (coef_s1[1][1]),
		.coef_2   (coef_s1[1][2]),
		.x_0      (x_s1[0]),
		.x_1      (x_s1[1]),
		.x_2      (x_s1[2]),
		.post_off (post_s1[1]),
		.res      (res_b),
		.clip     (clip_b)
	);

	cscm_row #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_row_c (
		.clk      (clk),
		.coef_0   (coef_s1[2][0]),
		.coef_1   (coef_s1[2][1]),
		.coef_2   (coef_s1[2][2]),
		.x_0      (x_s1[0]),
		.x_1      (x_s1[1]),
		.x_2      (x_s1[2]),
		.post_off (post_s1[2]),
		.res      (res_c),
		.clip     (clip_c)
	);

	// result strobe and combined clip flag
	assign done    = valid_s4;
	assign clipped = clip_a | clip_b | clip_c;

endmodule
